// File: rtl/ipf_pkg.sv
// Shared constants, types and helpers for the integer prime factorizer.
package ipf_pkg;

   localparam int VALUE_BITS  = 31;                      // width of the factor port
   localparam int IN_BITS     = 32;                      // signed request value
   localparam int N_BITS      = IN_BITS - 1;             // magnitude of a positive value
   localparam int ROOT_BITS   = (N_BITS + 1) / 2;        // floor(sqrt) and divisor width
   localparam int SQ_BITS     = 2 * ROOT_BITS;
   localparam int MAX_RESULTS = 30;
   localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);
   localparam int STEP_BITS   = $clog2(N_BITS);
   localparam int RIDX_BITS   = $clog2(ROOT_BITS);

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture request, reset divisor, count and root
      logic root_step;   // one bit of the square root
      logic div_start;   // start n / d
      logic div_step;    // one quotient bit
      logic next_d;      // advance candidate divisor
      logic emit_spec;   // missing or empty response
      logic emit_d;      // divisor is a factor: emit it, n <= quotient
      logic emit_n;      // emit remaining cofactor
   } ipf_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic special;     // request at the port is missing or below two
      logic root_last;
      logic div_last;
      logic rem_zero;
      logic more;        // d <= root, n > 1, room for another factor
      logic tail;        // n > 1, room for another factor
      logic out_free;    // response register can take a new response
   } ipf_sts_type;

   function automatic logic [VALUE_BITS-1:0] to_factor(input logic [N_BITS-1:0] n);
      logic [VALUE_BITS-1:0] f;
      f = '0;
      for (int i = 0; i < VALUE_BITS; i++) begin
         if (i < N_BITS) begin
            f[i] = n[i];
         end
      end
      return f;
   endfunction

endpackage

// File: rtl/ipf_ctrl.sv
// Sequencer for trial division: root, divide, test, emit.
module ipf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ipf_pkg::ipf_sts_type sts,
   output ipf_pkg::ipf_cmd_type cmd
);
   import ipf_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SPEC  = 7'b0000010,
      S_ROOT  = 7'b0000100,
      S_LOOP  = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_EMITD = 7'b0100000,
      S_EMITN = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.special ? S_SPEC : S_ROOT;
            end
         end
         S_SPEC: begin
            if (sts.out_free) begin
               cmd.emit_spec = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (sts.root_last) begin
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (sts.more) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (sts.tail) begin
               state_in = S_EMITN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_EMITD;
            end
         end
         S_EMITD: begin
            if (!sts.rem_zero) begin
               cmd.next_d = 1'b1;
               state_in   = S_LOOP;
            end else if (sts.out_free) begin
               cmd.emit_d = 1'b1;
               state_in   = S_LOOP;   // same divisor is tried again
            end
         end
         S_EMITN: begin
            if (sts.out_free) begin
               cmd.emit_n = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/ipf_datapath.sv
// Cofactor, bitwise square root, restoring divider and response register.
module ipf_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic signed [31:0]             req_value,
   input  logic                           req_is_missing,
   input  ipf_pkg::ipf_cmd_type           cmd,
   output ipf_pkg::ipf_sts_type           sts,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ipf_pkg::VALUE_BITS-1:0] rsp_factor,
   output logic                           rsp_last,
   output logic                           rsp_empty_res,
   output logic                           rsp_missing
);
   import ipf_pkg::*;

   logic [N_BITS-1:0]     n_ff, n_in;
   logic [N_BITS-1:0]     work_ff, work_in;    // dividend in, quotient out
   logic [ROOT_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0]  d_ff, d_in;
   logic [ROOT_BITS-1:0]  root_ff, root_in;
   logic [RIDX_BITS-1:0]  ridx_ff, ridx_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  miss_ff, miss_in;

   logic                  out_valid_ff, out_valid_in;
   logic [VALUE_BITS-1:0] out_factor_ff, out_factor_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_empty_ff, out_empty_in;
   logic                  out_miss_ff, out_miss_in;

   logic [ROOT_BITS-1:0]  trial;
   logic [SQ_BITS-1:0]    trial_sq;
   logic [ROOT_BITS:0]    shifted;
   logic                  sub_ok;
   logic                  n_gt1;
   logic                  room;
   logic                  out_free;
   logic                  load_out;

   assign trial    = root_ff | (ROOT_BITS'(1) << ridx_ff);
   assign trial_sq = SQ_BITS'(trial) * SQ_BITS'(trial);
   assign shifted  = {rem_ff, work_ff[N_BITS-1]};
   assign sub_ok   = shifted >= {1'b0, d_ff};
   assign n_gt1    = n_ff > N_BITS'(1);
   assign room     = cnt_ff < CNT_BITS'(MAX_RESULTS);
   assign out_free = !out_valid_ff || !rsp_stall;
   assign load_out = cmd.emit_spec || cmd.emit_d || cmd.emit_n;

   assign sts.special   = req_is_missing || req_value[IN_BITS-1] ||
                          (req_value[IN_BITS-1:1] == '0);
   assign sts.root_last = (ridx_ff == '0);
   assign sts.div_last  = (step_ff == STEP_BITS'(N_BITS - 1));
   assign sts.rem_zero  = (rem_ff == '0);
   assign sts.more      = (d_ff <= root_ff) && n_gt1 && room;
   assign sts.tail      = n_gt1 && room;
   assign sts.out_free  = out_free;

   always_comb begin
      n_in    = n_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      root_in = root_ff;
      ridx_in = ridx_ff;
      step_in = step_ff;
      cnt_in  = cnt_ff;
      miss_in = miss_ff;
      if (cmd.load) begin
         n_in    = req_value[N_BITS-1:0];
         miss_in = req_is_missing;
         d_in    = ROOT_BITS'(2);
         root_in = '0;
         ridx_in = RIDX_BITS'(ROOT_BITS - 1);
         cnt_in  = '0;
      end
      if (cmd.root_step) begin
         if (trial_sq <= SQ_BITS'(n_ff)) begin
            root_in = trial;
         end
         ridx_in = ridx_ff - RIDX_BITS'(1);
      end
      if (cmd.div_start) begin
         work_in = n_ff;
         rem_in  = '0;
         step_in = '0;
      end
      if (cmd.div_step) begin
         rem_in  = sub_ok ? ROOT_BITS'(shifted - {1'b0, d_ff}) : shifted[ROOT_BITS-1:0];
         work_in = {work_ff[N_BITS-2:0], sub_ok};
         step_in = step_ff + STEP_BITS'(1);
      end
      if (cmd.next_d) begin
         d_in = (d_ff == ROOT_BITS'(2)) ? ROOT_BITS'(3) : d_ff + ROOT_BITS'(2);
      end
      if (cmd.emit_d) begin
         n_in   = work_ff;
         cnt_in = cnt_ff + CNT_BITS'(1);
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && rsp_stall;
      out_factor_in = out_factor_ff;
      out_last_in   = out_last_ff;
      out_empty_in  = out_empty_ff;
      out_miss_in   = out_miss_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_empty_in = 1'b0;
         out_miss_in  = 1'b0;
         out_last_in  = 1'b1;
         if (cmd.emit_spec) begin
            out_factor_in = '0;
            out_empty_in  = !miss_ff;
            out_miss_in   = miss_ff;
         end else if (cmd.emit_d) begin
            out_factor_in = to_factor(N_BITS'(d_ff));
            // last when the cofactor drops to one or the count limit is hit
            out_last_in   = (work_ff == N_BITS'(1)) ||
                            (cnt_ff == CNT_BITS'(MAX_RESULTS - 1));
         end else begin
            out_factor_in = to_factor(n_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      work_ff       <= work_in;
      rem_ff        <= rem_in;
      d_ff          <= d_in;
      root_ff       <= root_in;
      ridx_ff       <= ridx_in;
      step_ff       <= step_in;
      cnt_ff        <= cnt_in;
      miss_ff       <= miss_in;
      out_factor_ff <= out_factor_in;
      out_last_ff   <= out_last_in;
      out_empty_ff  <= out_empty_in;
      out_miss_ff   <= out_miss_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_factor    = out_factor_ff;
   assign rsp_last      = out_last_ff;
   assign rsp_empty_res = out_empty_ff;
   assign rsp_missing   = out_miss_ff;

endmodule

// File: rtl/integer_prime_factorizer.sv
// A missing or sub-two request gives its one response once the response register is free.
// Otherwise the square root is found bit by bit, then each divisor test runs through a test,
// a serial divide and a check; each factor found repeats the test once.
// Requests are taken one at a time; the serial restoring divider (one quotient bit a cycle)
// sets the pace. A new request is taken once the last response is registered.
// Reset (synchronous, active high) clears the sequencer and the response valid only.
module integer_prime_factorizer (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [31:0]             req_value,
   input  logic                           req_is_missing,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ipf_pkg::VALUE_BITS-1:0] rsp_factor,
   output logic                           rsp_last,
   output logic                           rsp_empty_res,
   output logic                           rsp_missing
);
   import ipf_pkg::*;

   ipf_cmd_type cmd;
   ipf_sts_type sts;

   // Sequencer: takes a request in idle, then drives root, divide and emit steps.
   ipf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: cofactor n, candidate d, floor(sqrt) of the original value,
   // one-bit-per-cycle divider and the response register that decouples
   // the response side from the sequencer.
   ipf_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .req_is_missing (req_is_missing),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_factor     (rsp_factor),
      .rsp_last       (rsp_last),
      .rsp_empty_res  (rsp_empty_res),
      .rsp_missing    (rsp_missing)
   );

   // a taken request always makes the block busy on the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken but block not busy");

   // empty and missing responses are single, zero-factor responses
   a_flag_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_empty_res || rsp_missing) |->
         rsp_last && (rsp_factor == '0) && !(rsp_empty_res && rsp_missing))
      else $error("bad empty/missing response");

   // a real factor is at least two
   a_factor_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_empty_res && !rsp_missing |-> rsp_factor >= VALUE_BITS'(2))
      else $error("factor below two");

endmodule
